FILE: design/xrg_pkg.sv
package xrg_pkg;

    localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

    localparam logic [2:0] FN_SEED    = 3'd0;
    localparam logic [2:0] FN_RAW     = 3'd1;
    localparam logic [2:0] FN_MOD     = 3'd2;
    localparam logic [2:0] FN_IVL     = 3'd3;
    localparam logic [2:0] FN_UNIT    = 3'd4;
    localparam logic [2:0] FN_CHANCE  = 3'd5;
    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]         func;
        logic [63:0]        value;
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
    } in_t;

    typedef struct packed {
        logic [63:0]        draw_value;
        logic signed [31:0] interval_value;
        logic               hit;
    } out_t;

    typedef enum logic [2:0] {
        OP_CONST,
        OP_SEED,
        OP_RAW,
        OP_MOD,
        OP_IVL,
        OP_UNIT,
        OP_CHANCE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] operand;
        logic [31:0] lo;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_ADD,
        ST_SEED_X30,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SEED_X27,
        ST_SEED_X31,
        ST_SEED_FIX,
        ST_DRAW,
        ST_DIV
    } bk_state_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int k);
        return (v << k) | (v >> (64 - k));
    endfunction

endpackage

FILE: design/xrg_front.sv
module xrg_front import xrg_pkg::*; (
    input  in_t  s_data,
    output cmd_t cmd
);

    logic signed [32:0] span;

    always_comb begin
        span        = {s_data.high_bound[31], s_data.high_bound}
                    - {s_data.low_bound[31], s_data.low_bound} + 33'sd1;
        cmd.op      = OP_CONST;
        cmd.operand = s_data.value;
        cmd.lo      = '0;
        case (s_data.func)
            FN_SEED:   cmd.op = OP_SEED;
            FN_RAW:    cmd.op = OP_RAW;
            FN_MOD: begin
                if (s_data.value != 64'd0) begin
                    cmd.op = OP_MOD;
                end
            end
            FN_IVL: begin
                cmd.lo      = s_data.low_bound;
                cmd.operand = {31'd0, span};
                if (s_data.high_bound > s_data.low_bound) begin
                    cmd.op = OP_IVL;
                end
            end
            FN_UNIT:   cmd.op = OP_UNIT;
            FN_CHANCE: cmd.op = OP_CHANCE;
            default:   cmd.op = OP_CONST;
        endcase
    end

endmodule

FILE: design/xrg_queue.sv
module xrg_queue import xrg_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: design/xrg_modu.sv
module xrg_modu import xrg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] rem
);

    logic [63:0] q_reg, rem_reg, d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] trial;
    logic [65:0] diff;

    assign trial = {rem_reg, q_reg[63]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};
    assign done  = done_reg;
    assign rem   = rem_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[62:0], 1'b0};
            rem_reg <= diff[65] ? trial[63:0] : diff[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/xrg_back.sv
module xrg_back import xrg_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    bk_state_t   state_reg, state_next;
    logic [63:0] s_reg [4];
    logic [63:0] acc_reg, z_reg, p0_reg;
    logic [31:0] pc_reg;
    logic [1:0]  idx_reg;
    logic        sel_reg, emit_reg, out_valid_reg;
    cmd_t        cmd_reg;
    out_t        res_reg;

    logic [63:0] mul_b, draw, n0, n1, n2, n3, t, frac;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic        div_start, div_done;
    logic [63:0] div_rem;

    xrg_modu u_modu (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (draw),
        .divisor  (cmd_reg.operand),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = res_reg;

    always_comb begin
        mul_b = sel_reg ? MIX_MUL_B : MIX_MUL_A;
        ma    = z_reg[31:0];
        mb    = mul_b[31:0];
        case (state_reg)
            ST_MUL1: mb = mul_b[63:32];
            ST_MUL2: ma = z_reg[63:32];
            default: ;
        endcase
        prod = ma * mb;

        draw = rotl64(s_reg[0] + s_reg[3], 23) + s_reg[0];
        frac = {11'd0, draw[63:11]};
        t    = s_reg[1] << 17;
        n2   = s_reg[2] ^ s_reg[0];
        n3   = s_reg[3] ^ s_reg[1];
        n1   = s_reg[1] ^ n2;
        n0   = s_reg[0] ^ n3;
        n2   = n2 ^ t;
        n3   = rotl64(n3, 45);

        cmd_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
        div_start  = (state_reg == ST_DRAW)
                   && (cmd_reg.op == OP_MOD || cmd_reg.op == OP_IVL);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    if (cmd.op == OP_SEED) begin
                        state_next = ST_SEED_ADD;
                    end else if (cmd.op != OP_CONST) begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_SEED_ADD: state_next = ST_SEED_X30;
            ST_SEED_X30: state_next = ST_MUL0;
            ST_MUL0:     state_next = ST_MUL1;
            ST_MUL1:     state_next = ST_MUL2;
            ST_MUL2:     state_next = ST_MUL3;
            ST_MUL3:     state_next = sel_reg ? ST_SEED_X31 : ST_SEED_X27;
            ST_SEED_X27: state_next = ST_MUL0;
            ST_SEED_X31: state_next = (idx_reg == 2'd3) ? ST_SEED_FIX : ST_SEED_ADD;
            ST_SEED_FIX: state_next = ST_IDLE;
            ST_DRAW:     state_next = div_start ? ST_DIV : ST_IDLE;
            ST_DIV:      state_next = div_done ? ST_IDLE : ST_DIV;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            idx_reg <= 2'd0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        cmd_reg <= cmd;
                        acc_reg <= cmd.operand;
                        idx_reg <= 2'd0;
                        res_reg <= '{draw_value: '0, interval_value: cmd.lo, hit: 1'b0};
                    end
                end
                ST_SEED_ADD: begin
                    acc_reg <= acc_reg + GOLDEN_INC;
                    z_reg   <= acc_reg + GOLDEN_INC;
                end
                ST_SEED_X30: begin
                    z_reg   <= z_reg ^ (z_reg >> 30);
                    sel_reg <= 1'b0;
                end
                ST_MUL0: p0_reg <= prod;
                ST_MUL1: pc_reg <= prod[31:0];
                ST_MUL2: pc_reg <= pc_reg + prod[31:0];
                ST_MUL3: z_reg  <= p0_reg + {pc_reg, 32'd0};
                ST_SEED_X27: begin
                    z_reg   <= z_reg ^ (z_reg >> 27);
                    sel_reg <= 1'b1;
                end
                ST_SEED_X31: begin
                    s_reg[idx_reg] <= z_reg ^ (z_reg >> 31);
                    idx_reg        <= idx_reg + 2'd1;
                end
                ST_SEED_FIX: begin
                    if ((s_reg[0] | s_reg[1] | s_reg[2] | s_reg[3]) == 64'd0) begin
                        s_reg[0] <= 64'd1;
                    end
                    res_reg <= '0;
                end
                ST_DRAW: begin
                    s_reg[0] <= n0;
                    s_reg[1] <= n1;
                    s_reg[2] <= n2;
                    s_reg[3] <= n3;
                    case (cmd_reg.op)
                        OP_RAW:    res_reg.draw_value <= draw;
                        OP_UNIT:   res_reg.draw_value <= frac;
                        OP_CHANCE: begin
                            res_reg.draw_value <= frac;
                            res_reg.hit        <= (frac < cmd_reg.operand);
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (cmd_reg.op == OP_MOD) begin
                            res_reg.draw_value <= div_rem;
                        end else begin
                            res_reg.interval_value <= cmd_reg.lo + div_rem[31:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SEED_ADD;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        emit_reg <= 1'b1;
                        if (cmd.op == OP_CONST) out_valid_reg <= 1'b1;
                    end
                end
                ST_SEED_FIX: out_valid_reg <= emit_reg;
                ST_DRAW:     if (!div_start) out_valid_reg <= 1'b1;
                ST_DIV:      if (div_done) out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule

FILE: design/xoshiro_random_generator.sv
// Paths, accept to result valid: raw, unit and chance pass through the draw state; zero
// modulus, empty interval and unused selector answer from idle; modulo and interval add the
// bit-serial 64-step remainder unit; seed runs four splitmix rounds, each with two 64-bit
// products built from three 32x32 partials.
// Throughput: one transaction at a time in the back end, the next once the result is taken.
// Reset: synchronous active-low; a seed-zero pass follows, 2-entry queue still fills.
module xoshiro_random_generator import xrg_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t front_cmd, q_cmd;
    logic q_valid, q_ready;

    xrg_front u_front (
        .s_data (s_data),
        .cmd    (front_cmd)
    );

    xrg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    xrg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: bench/xrg_checker.sv
`timescale 1ns / 100ps

module xrg_checker import xrg_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   fail_count,
    output int   pending,
    output int   results_seen
);

    logic [63:0] gen_word [4];
    out_t        expected_q [$];

    function automatic logic [63:0] rot_word(input logic [63:0] v, input int k);
        return (v << k) | (v >> (64 - k));
    endfunction

    function automatic logic [63:0] splitmix(ref logic [63:0] acc);
        logic [63:0] z;
        acc = acc + GOLDEN_INC;
        z = acc;
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    function automatic void expand_seed(input logic [63:0] seed);
        logic [63:0] acc;
        acc = seed;
        for (int i = 0; i < 4; i++) gen_word[i] = splitmix(acc);
        if ((gen_word[0] | gen_word[1] | gen_word[2] | gen_word[3]) == 64'd0)
            gen_word[0] = 64'd1;
    endfunction

    function automatic void step_generator(output logic [63:0] draw);
        logic [63:0] t;
        draw = rot_word(gen_word[0] + gen_word[3], 23) + gen_word[0];
        t = gen_word[1] << 17;
        gen_word[2] ^= gen_word[0];
        gen_word[3] ^= gen_word[1];
        gen_word[1] ^= gen_word[2];
        gen_word[0] ^= gen_word[3];
        gen_word[2] ^= t;
        gen_word[3] = rot_word(gen_word[3], 45);
    endfunction

    function automatic out_t predict_result(input in_t req);
        out_t        res;
        logic [63:0] draw, lo, hi;
        res = '0;
        case (req.func)
            FN_SEED: begin
                expand_seed(req.value);
            end
            FN_RAW: begin
                step_generator(draw);
                res.draw_value = draw;
            end
            FN_MOD: begin
                if (req.value != 0) begin
                    step_generator(draw);
                    res.draw_value = draw % req.value;
                end
            end
            FN_IVL: begin
                lo = 64'(req.low_bound);
                hi = 64'(req.high_bound);
                if (req.high_bound <= req.low_bound) begin
                    res.interval_value = req.low_bound;
                end else begin
                    step_generator(draw);
                    res.interval_value = 32'(lo + draw % (hi - lo + 64'd1));
                end
            end
            FN_UNIT: begin
                step_generator(draw);
                res.draw_value = draw >> 11;
            end
            FN_CHANCE: begin
                step_generator(draw);
                res.draw_value = draw >> 11;
                res.hit = (draw >> 11) < req.value;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        int   errs;
        errs = 0;
        if (!aresetn) begin
            expand_seed(64'd0);
            expected_q.delete();
            fail_count <= 0;
            results_seen <= 0;
            pending <= 0;
        end else begin
            if (s_valid && s_ready) expected_q.push_back(predict_result(s_data));
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction %p", m_data);
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.draw_value !== want.draw_value) begin
                        $error("draw_value: expected %h, got %h",
                               want.draw_value, m_data.draw_value);
                        errs++;
                    end
                    if (m_data.interval_value !== want.interval_value) begin
                        $error("interval_value: expected %0d, got %0d",
                               want.interval_value, m_data.interval_value);
                        errs++;
                    end
                    if (m_data.hit !== want.hit) begin
                        $error("hit: expected %b, got %b", want.hit, m_data.hit);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= expected_q.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import xrg_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int fail_count, pending, results_seen;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    int items_sent = 0;
    int quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    xoshiro_random_generator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    xrg_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // receiver: random stalls, long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_item(input in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic in_t make_req(input logic [2:0] f, input logic [63:0] v,
                                     input int lo, input int hi);
        in_t r;
        r.func = f;
        r.value = v;
        r.low_bound = lo;
        r.high_bound = hi;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic in_t random_req();
        in_t r;
        int  pick;
        r = make_req(3'($urandom_range(7)), rand64(), $urandom(), $urandom());
        pick = $urandom_range(9);
        if (r.func == FN_MOD && pick < 5) r.value = 64'($urandom_range(pick == 0 ? 0 : 1000));
        if (r.func == FN_CHANCE && pick < 7) r.value = rand64() >> (pick < 5 ? 11 : 10);
        if (r.func == FN_IVL && pick < 4) r.high_bound = r.low_bound + $urandom_range(200);
        if (r.func == FN_SEED && pick < 2) r.value = 64'(pick);
        return r;
    endfunction

    initial begin
        in_t directed [$];
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        directed = '{
            make_req(FN_RAW, 0, 0, 0),
            make_req(FN_UNIT, 0, 0, 0),
            make_req(FN_SEED, 64'd0, 0, 0),
            make_req(FN_SEED, 64'h61c8864680b583eb, 0, 0),
            make_req(FN_SEED, '1, 0, 0),
            make_req(FN_RAW, '1, -1, -1),
            make_req(FN_MOD, 64'd0, 0, 0),
            make_req(FN_MOD, 64'd1, 0, 0),
            make_req(FN_MOD, '1, 0, 0),
            make_req(FN_MOD, 64'd7, 0, 0),
            make_req(FN_IVL, 0, 5, 5),
            make_req(FN_IVL, 0, 7, -3),
            make_req(FN_IVL, 0, 32'sh80000000, 32'sh7fffffff),
            make_req(FN_IVL, 0, -10, 10),
            make_req(FN_IVL, 0, 32'sh7fffffff, 32'sh80000000),
            make_req(FN_CHANCE, 64'd0, 0, 0),
            make_req(FN_CHANCE, 64'h20000000000000, 0, 0),
            make_req(FN_CHANCE, '1, 0, 0),
            make_req(FN_CHANCE, 64'h10000000000000, 0, 0),
            make_req(FN_SPARE_A, '1, -1, -1),
            make_req(FN_SPARE_B, 0, 0, 0),
            make_req(FN_UNIT, 0, 0, 0)
        };
        foreach (directed[i]) send_item(directed[i]);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 57 : 36) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 57 : 36) : 0;
            if (ph == 0) fork
                begin
                    hold_off = 1'b1;
                    repeat (300) @(negedge aclk);
                    hold_off = 1'b0;
                end
            join_none
            repeat (195) send_item(random_req());
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;

        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("run covered %0d input transactions and %0d results", items_sent,
                 results_seen);
        $display("all operations, seed/interval/chance edge cases, four idle patterns");
        if (fail_count == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
design/xrg_pkg.sv
design/xrg_front.sv
design/xrg_queue.sv
design/xrg_modu.sv
design/xrg_back.sv
design/xoshiro_random_generator.sv
bench/xrg_checker.sv
bench/tb_top.sv
